>>> sv/sopa_pkg.sv
// Shared types, codes and constants of the slab object pool allocator.
// No dependencies; every other file imports this package.
package sopa_pkg;

    localparam int ADDR_W          = 48;
    localparam int SIZE_W          = 12;
    localparam int IDX_W           = 10;
    localparam int STEP_W          = 4;
    localparam int MAX_OBJECTS_DEF = 512;
    localparam int CFG_IDX_W       = 2;

    localparam logic [SIZE_W-1:0] MAX_REQUEST   = 12'd2048;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 12'd16;
    localparam logic [IDX_W-1:0]  COUNT_RESET   = 10'd512;
    localparam logic [ADDR_W-1:0] BASE_RESET    = '0;

    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE    = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef logic [2:0] status_t;
    localparam status_t STATUS_OK             = 3'd0;
    localparam status_t STATUS_TOO_LARGE      = 3'd1;
    localparam status_t STATUS_NO_FREE        = 3'd2;
    localparam status_t STATUS_NOTHING_IN_USE = 3'd3;
    localparam status_t STATUS_OUT_OF_POOL    = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_FREE_OFS,
        ST_FREE_RANGE,
        ST_FREE_DIV,
        ST_FREE_CHK,
        ST_DONE
    } sopa_state_t;

    typedef struct packed {
        logic [SIZE_W-1:0] object_size;
        logic [IDX_W-1:0]  object_count;
        logic [ADDR_W-1:0] pool_base;
    } sopa_cfg_t;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } sopa_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] object_address;
        status_t           status;
    } sopa_res_t;

endpackage

>>> sv/sopa_alu.sv
// Shared 48-bit add/subtract unit with carry out for the allocator sequencer.
// Depends on sopa_pkg.
module sopa_alu
    import sopa_pkg::*;
(
    input  logic [ADDR_W-1:0] a,
    input  logic [ADDR_W-1:0] b,
    input  logic              sub,
    output logic [ADDR_W-1:0] sum,
    output logic              carry
);

    logic [ADDR_W:0]   full;
    logic [ADDR_W-1:0] b_op;

    assign b_op  = sub ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, sub};
    assign sum   = full[ADDR_W-1:0];
    assign carry = full[ADDR_W];

endmodule

>>> sv/sopa_link_ram.sv
// Free-list link memory with registered read and a clearing pass after reset
// that loads entry i with i+1. Depends on sopa_pkg.
module sopa_link_ram
    import sopa_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    parameter int RAM_AW      = $clog2(MAX_OBJECTS),
    parameter int LINK_W      = $clog2(MAX_OBJECTS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [RAM_AW-1:0] wr_addr,
    input  logic [LINK_W-1:0] wr_data,
    input  logic [RAM_AW-1:0] rd_addr,
    output logic [LINK_W-1:0] rd_data,
    output logic              clearing
);

    logic [LINK_W-1:0] mem [MAX_OBJECTS];
    logic [RAM_AW-1:0] clr_cnt_reg;
    logic [RAM_AW-1:0] clr_cnt_next;
    logic              clearing_reg;
    logic              clearing_next;
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [LINK_W-1:0] wdata;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (int'(clr_cnt_reg) == MAX_OBJECTS - 1)
            begin
                clearing_next = 1'b0;
            end
        end
        we    = clearing_reg | wr_en;
        waddr = clearing_reg ? clr_cnt_reg : wr_addr;
        wdata = clearing_reg ? (LINK_W'(clr_cnt_reg) + LINK_W'(1)) : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[rd_addr];
    end

    assign clearing = clearing_reg;

endmodule

>>> sv/sopa_ctrl.sv
// Sequencer of the allocator: list head, in-use count, shift-add address
// build and restoring division on the shared unit. Depends on sopa_pkg,
// sopa_alu.
module sopa_ctrl
    import sopa_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    parameter int RAM_AW      = $clog2(MAX_OBJECTS),
    parameter int LINK_W      = $clog2(MAX_OBJECTS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sopa_cfg_t         cfg,
    input  logic              req_valid,
    output logic              req_ready,
    input  sopa_req_t         req,
    output logic              res_valid,
    input  logic              res_ready,
    output sopa_res_t         res,
    output logic [RAM_AW-1:0] ram_rd_addr,
    input  logic [LINK_W-1:0] ram_rd_data,
    output logic              ram_wr_en,
    output logic [RAM_AW-1:0] ram_wr_addr,
    output logic [LINK_W-1:0] ram_wr_data,
    input  logic              clearing
);

    sopa_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] acc_reg, acc_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  quot_reg, quot_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0]  in_use_reg, in_use_next;
    sopa_res_t         res_reg, res_next;

    logic [IDX_W-1:0]  count;
    logic [IDX_W-1:0]  head_ext;
    logic [ADDR_W-1:0] size_sh;
    logic [ADDR_W-1:0] alu_b;
    logic [ADDR_W-1:0] alu_sum;
    logic              alu_carry;
    logic              alu_sub;
    logic [ADDR_W-1:0] acc_add;

    assign count    = (int'(cfg.object_count) > MAX_OBJECTS) ? IDX_W'(MAX_OBJECTS)
                                                             : cfg.object_count;
    assign head_ext = IDX_W'(head_reg);
    assign size_sh  = ADDR_W'(cfg.object_size) << step_reg;
    assign alu_b    = (state_reg == ST_FREE_OFS) ? cfg.pool_base : size_sh;
    assign alu_sub  = (state_reg != ST_ALLOC);
    assign acc_add  = head_ext[step_reg] ? alu_sum : acc_reg;

    sopa_alu u_alu (
        .a     (acc_reg),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        step_next   = step_reg;
        quot_next   = quot_reg;
        head_next   = head_reg;
        in_use_next = in_use_reg;
        res_next    = res_reg;
        ram_wr_en   = 1'b0;
        req_ready   = (state_reg == ST_IDLE);
        res_valid   = (state_reg == ST_DONE);

        case (state_reg)
            ST_CLEAR:
            begin
                if (!clearing)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_next.object_address = '0;
                    if (req.action == ACT_ALLOC)
                    begin
                        if (req.request_size > cfg.object_size ||
                            req.request_size > MAX_REQUEST)
                        begin
                            res_next.status = STATUS_TOO_LARGE;
                            state_next      = ST_DONE;
                        end
                        else if (in_use_reg >= count || int'(head_reg) >= int'(count))
                        begin
                            res_next.status = STATUS_NO_FREE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            acc_next   = cfg.pool_base;
                            step_next  = '0;
                            state_next = ST_ALLOC;
                        end
                    end
                    else
                    begin
                        if (in_use_reg == '0)
                        begin
                            res_next.status = STATUS_NOTHING_IN_USE;
                            state_next      = ST_DONE;
                        end
                        else if (cfg.object_size == '0)
                        begin
                            res_next.status = STATUS_OUT_OF_POOL;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            acc_next   = req.free_address;
                            state_next = ST_FREE_OFS;
                        end
                    end
                end
            end
            ST_ALLOC:
            begin
                acc_next = acc_add;
                if (int'(step_reg) == IDX_W - 1)
                begin
                    res_next.object_address = acc_add;
                    res_next.status         = STATUS_OK;
                    head_next               = ram_rd_data;
                    in_use_next             = in_use_reg + 1'b1;
                    state_next              = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FREE_OFS:
            begin
                if (!alu_carry)
                begin
                    res_next.status = STATUS_OUT_OF_POOL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    acc_next   = alu_sum;
                    step_next  = STEP_W'(IDX_W);
                    state_next = ST_FREE_RANGE;
                end
            end
            ST_FREE_RANGE:
            begin
                if (alu_carry)
                begin
                    res_next.status = STATUS_OUT_OF_POOL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    quot_next  = '0;
                    step_next  = STEP_W'(IDX_W - 1);
                    state_next = ST_FREE_DIV;
                end
            end
            ST_FREE_DIV:
            begin
                if (alu_carry)
                begin
                    acc_next            = alu_sum;
                    quot_next[step_reg] = 1'b1;
                end
                if (step_reg == '0)
                begin
                    state_next = ST_FREE_CHK;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_FREE_CHK:
            begin
                if (quot_reg >= count)
                begin
                    res_next.status = STATUS_OUT_OF_POOL;
                end
                else
                begin
                    ram_wr_en       = 1'b1;
                    head_next       = LINK_W'(quot_reg);
                    in_use_next     = in_use_reg - 1'b1;
                    res_next.status = STATUS_OK;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            head_reg   <= '0;
            in_use_reg <= '0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            in_use_reg <= in_use_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        quot_reg <= quot_next;
        res_reg  <= res_next;
    end

    assign res         = res_reg;
    assign ram_rd_addr = RAM_AW'(head_reg);
    assign ram_wr_addr = RAM_AW'(quot_reg);
    assign ram_wr_data = head_reg;

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !req_ready)
        else $error("item accepted during link clearing pass");

    a_free_drops_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        ram_wr_en |=> in_use_reg == IDX_W'($past(in_use_reg) - 1'b1))
        else $error("in-use count not dropped on free");

    a_fail_zero_address: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res.status != STATUS_OK) |-> res.object_address == '0)
        else $error("failed item carries an address");

    a_accept_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");

endmodule

>>> sv/slab_object_pool_allocator.sv
// Top level of the slab object pool allocator: configuration registers,
// result output register, sequencer and link memory. Depends on sopa_pkg,
// sopa_ctrl, sopa_link_ram.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tuser: action; tdata: request_size, free_address
//  m_axis    | out       | tdata: object_address, status
//  cfg       | in        | cfg_index, cfg_data (register write)
//
//  Allocate: the address is built by ten shift-add steps on the shared adder.
//  Free: the index is found by the offset subtract, range check and ten
//  restoring division steps. After reset the link memory is loaded one entry
//  a cycle, all MAX_OBJECTS entries, and s_axis_tready stays low meanwhile;
//  cfg writes are taken at any time. One item is in work at a time; the result
//  register holds while m_axis stalls.
module slab_object_pool_allocator
    import sopa_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // request_size[11:0], free_address[59:12]
    input  logic                 s_axis_tuser,  // action
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,  // object_address[47:0], status[50:48]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int RAM_AW = $clog2(MAX_OBJECTS);
    localparam int LINK_W = $clog2(MAX_OBJECTS + 1);

    sopa_cfg_t         cfg_reg, cfg_next;
    sopa_req_t         req;
    sopa_res_t         res;
    sopa_res_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic              res_valid;
    logic              res_ready;
    logic [RAM_AW-1:0] ram_rd_addr;
    logic [LINK_W-1:0] ram_rd_data;
    logic              ram_wr_en;
    logic [RAM_AW-1:0] ram_wr_addr;
    logic [LINK_W-1:0] ram_wr_data;
    logic              clearing;

    assign req.action       = s_axis_tuser;
    assign req.request_size = s_axis_tdata[11:0];
    assign req.free_address = s_axis_tdata[59:12];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_OBJECT_SIZE:  cfg_next.object_size  = cfg_data[SIZE_W-1:0];
                REG_OBJECT_COUNT: cfg_next.object_count = cfg_data[IDX_W-1:0];
                REG_POOL_BASE:    cfg_next.pool_base    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.object_size  <= SIZE_RESET;
            cfg_reg.object_count <= COUNT_RESET;
            cfg_reg.pool_base    <= BASE_RESET;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.status, out_reg.object_address};

    sopa_ctrl #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .RAM_AW      (RAM_AW),
        .LINK_W      (LINK_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .clearing    (clearing)
    );

    sopa_link_ram #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .RAM_AW      (RAM_AW),
        .LINK_W      (LINK_W)
    ) u_link_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (ram_wr_en),
        .wr_addr  (ram_wr_addr),
        .wr_data  (ram_wr_data),
        .rd_addr  (ram_rd_addr),
        .rd_data  (ram_rd_data),
        .clearing (clearing)
    );

endmodule
